@@ src/dts_pkg.sv @@
package dts_pkg;

  // Node ids are fixed at seven bits by the item format.
  localparam int NODE_W       = 7;
  localparam int MAX_NODES    = 64;
  localparam int NODE_AW      = 6;
  localparam int MAX_EDGES_DEF = 256;
  localparam int DATA_W       = 32;
  localparam int ADDR_W       = 3;

  // Request codes on req_type.
  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_SORT = 1'b1;

  // Register index of node_count (word address bit).
  localparam logic REG_NODE_COUNT = 1'b0;
  localparam logic [NODE_W-1:0] NODE_COUNT_RST = 7'd64;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROOT,
    S_EDGE_RD,
    S_EDGE_CHK,
    S_MARK_CHK,
    S_POP_LD,
    S_CYC_OUT,
    S_EMIT_RD,
    S_EMIT_LD
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic idle;
    logic start_check;
    logic start_sort;
    logic root_next;
    logic root_start;
    logic retire;
    logic pop_rd;
    logic edge_rd;
    logic cursor_inc;
    logic match_take;
    logic push;
    logic load_top;
    logic emit_start;
    logic emit_rd;
    logic emit_out;
    logic cyc_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sort_req;
    logic check;
    logic i_gt_n;
    logic root_seen;
    logic c_ge_total;
    logic sp_one;
    logic sp_full;
    logic edge_match;
    logic mark_grey;
    logic mark_white;
    logic out_free;
    logic idx_zero;
  } sts_t;

endpackage

@@ src/dts_ram.sv @@
module dts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port; read data holds when idle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/dts_ctrl.sv @@
module dts_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  dts_pkg::sts_t sts,
  output dts_pkg::cmd_t cmd
);
  import dts_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (sts.sort_req) begin
          cmd.start_check = 1'b1;
          state_next = S_ROOT;
        end
      end
      S_ROOT: begin
        if (sts.i_gt_n) begin
          if (sts.check) begin
            cmd.start_sort = 1'b1;
          end else begin
            cmd.emit_start = 1'b1;
            state_next = S_EMIT_RD;
          end
        end else if (sts.root_seen) begin
          cmd.root_next = 1'b1;
        end else begin
          cmd.root_start = 1'b1;
          state_next = S_EDGE_RD;
        end
      end
      S_EDGE_RD: begin
        if (sts.c_ge_total) begin
          cmd.retire = 1'b1;
          if (sts.sp_one) begin
            cmd.root_next = 1'b1;
            state_next = S_ROOT;
          end else begin
            cmd.pop_rd = 1'b1;
            state_next = S_POP_LD;
          end
        end else begin
          cmd.edge_rd = 1'b1;
          state_next = S_EDGE_CHK;
        end
      end
      S_EDGE_CHK: begin
        cmd.cursor_inc = 1'b1;
        if (sts.edge_match) begin
          cmd.match_take = 1'b1;
          state_next = S_MARK_CHK;
        end else begin
          state_next = S_EDGE_RD;
        end
      end
      S_MARK_CHK: begin
        if (sts.mark_grey && sts.check) begin
          state_next = S_CYC_OUT;
        end else begin
          if (sts.mark_white && !sts.sp_full) begin
            cmd.push = 1'b1;
          end
          state_next = S_EDGE_RD;
        end
      end
      S_POP_LD: begin
        cmd.load_top = 1'b1;
        state_next = S_EDGE_RD;
      end
      S_CYC_OUT: begin
        if (sts.out_free) begin
          cmd.cyc_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_EMIT_RD: begin
        cmd.emit_rd = 1'b1;
        state_next = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        if (sts.out_free) begin
          cmd.emit_out = 1'b1;
          state_next = sts.idx_zero ? S_IDLE : S_EMIT_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ src/dts_dp.sv @@
module dts_dp #(
  parameter int MAX_EDGES = dts_pkg::MAX_EDGES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  dts_pkg::cmd_t               cmd,
  output dts_pkg::sts_t               sts,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dts_pkg::ADDR_W-1:0]  paddr,
  input  logic [dts_pkg::DATA_W-1:0]  pwdata,
  output logic [dts_pkg::DATA_W-1:0]  prdata,
  input  logic                        in_valid,
  input  logic                        req_type,
  input  logic [dts_pkg::NODE_W-1:0]  from_node,
  input  logic [dts_pkg::NODE_W-1:0]  to_node,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [dts_pkg::NODE_W-1:0]  node_id,
  output logic                        cycle_found,
  output logic                        edges_dropped,
  output logic                        last
);
  import dts_pkg::*;

  localparam int EW  = $clog2(MAX_EDGES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int SW  = NODE_W + EW;
  localparam logic [EW-1:0] EDGE_CAP = EW'(MAX_EDGES);
  localparam logic [NODE_W-1:0] NODE_CAP = NODE_W'(MAX_NODES);

  logic [NODE_W-1:0]  node_count;
  logic [NODE_W-1:0]  n;
  logic [EW-1:0]      edge_total;
  logic               drop_flag;
  logic               check;
  logic [NODE_W-1:0]  i;
  logic [NODE_W-1:0]  u;
  logic [EW-1:0]      c;
  logic [NODE_W-1:0]  sp;
  logic [NODE_W-1:0]  v;
  logic               seen_q;
  logic [MAX_NODES-1:0] seen;
  logic [NODE_W-1:0]  order_count;
  logic [NODE_AW-1:0] idx;

  logic               edge_load;
  logic               edge_ok;
  logic [2*NODE_W-1:0] edge_rdata;
  logic [NODE_W-1:0]  e_src;
  logic [NODE_W-1:0]  e_tgt;
  logic [NODE_W-1:0]  i_m1;
  logic [NODE_W-1:0]  u_m1;
  logic [NODE_W-1:0]  v_m1;
  logic [NODE_W-1:0]  t_m1;
  logic [NODE_W-1:0]  sp_m1;
  logic [NODE_W-1:0]  sp_m2;

  logic               mark_we;
  logic [NODE_AW-1:0] mark_waddr;
  logic               mark_wdata;
  logic               mark_rdata;
  logic [SW-1:0]      stack_rdata;
  logic [NODE_W-1:0]  order_rdata;
  logic               order_we;
  logic               out_free;

  function automatic logic [NODE_AW-1:0] sp_idx(input logic [NODE_W-1:0] cnt);
    logic [NODE_W-1:0] t;
    t = cnt - NODE_W'(1);
    return t[NODE_AW-1:0];
  endfunction

  // Configuration register port.
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= NODE_COUNT_RST;
    end else if (psel && penable && pwrite && (paddr[2] == REG_NODE_COUNT)) begin
      node_count <= pwdata[NODE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_NODE_COUNT) begin
      prdata = DATA_W'(node_count);
    end
  end

  // Active node count, saturated into one to the node capacity.
  always_comb begin
    if (node_count == '0) begin
      n = NODE_W'(1);
    end else if (node_count > NODE_CAP) begin
      n = NODE_CAP;
    end else begin
      n = node_count;
    end
  end

  assign edge_load = cmd.idle && in_valid && (req_type == REQ_ADD);
  assign edge_ok = (from_node != '0) && (from_node <= n) && (to_node != '0) &&
                   (to_node <= n) && (edge_total < EDGE_CAP);

  assign e_src = edge_rdata[2*NODE_W-1:NODE_W];
  assign e_tgt = edge_rdata[NODE_W-1:0];
  assign i_m1  = i - NODE_W'(1);
  assign u_m1  = u - NODE_W'(1);
  assign v_m1  = v - NODE_W'(1);
  assign t_m1  = e_tgt - NODE_W'(1);
  assign sp_m1 = sp - NODE_W'(1);
  assign sp_m2 = sp - NODE_W'(2);
  assign out_free = !out_valid || !out_stall;

  // Status toward the controller.
  always_comb begin
    sts.sort_req   = in_valid && (req_type == REQ_SORT);
    sts.check      = check;
    sts.i_gt_n     = i > n;
    sts.root_seen  = seen[i_m1[NODE_AW-1:0]];
    sts.c_ge_total = c >= edge_total;
    sts.sp_one     = sp == NODE_W'(1);
    sts.sp_full    = sp >= NODE_CAP;
    sts.edge_match = (e_src == u) && (e_tgt != '0) && (e_tgt <= n);
    sts.mark_grey  = seen_q && !mark_rdata;
    sts.mark_white = !seen_q;
    sts.out_free   = out_free;
    sts.idx_zero   = idx == '0;
  end

  // Edge store: source in the upper half, target in the lower half.
  dts_ram #(.WIDTH(2*NODE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (edge_load && edge_ok),
    .waddr (edge_total[EAW-1:0]),
    .wdata ({from_node, to_node}),
    .re    (cmd.edge_rd),
    .raddr (c[EAW-1:0]),
    .rdata (edge_rdata)
  );

  // Colour store: zero is grey, one is black; the seen bits mark white.
  always_comb begin
    mark_we    = 1'b0;
    mark_waddr = i_m1[NODE_AW-1:0];
    mark_wdata = 1'b0;
    if (cmd.root_start) begin
      mark_we = 1'b1;
    end else if (cmd.retire) begin
      mark_we    = 1'b1;
      mark_waddr = u_m1[NODE_AW-1:0];
      mark_wdata = 1'b1;
    end else if (cmd.push) begin
      mark_we    = 1'b1;
      mark_waddr = v_m1[NODE_AW-1:0];
    end
  end

  dts_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wdata),
    .re    (cmd.match_take),
    .raddr (t_m1[NODE_AW-1:0]),
    .rdata (mark_rdata)
  );

  // Walk stack below the cached top entry.
  dts_ram #(.WIDTH(SW), .DEPTH(MAX_NODES)) u_stack_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (sp_m1[NODE_AW-1:0]),
    .wdata ({u, c}),
    .re    (cmd.pop_rd),
    .raddr (sp_m2[NODE_AW-1:0]),
    .rdata (stack_rdata)
  );

  // Postorder store, read back from the top.
  assign order_we = cmd.retire && !check && (order_count < NODE_CAP);

  dts_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_order_ram (
    .clk   (clk),
    .we    (order_we),
    .waddr (order_count[NODE_AW-1:0]),
    .wdata (u),
    .re    (cmd.emit_rd),
    .raddr (idx),
    .rdata (order_rdata)
  );

  // Graph bookkeeping: edge count and drop flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_total <= '0;
      drop_flag  <= 1'b0;
    end else if (cmd.cyc_out || (cmd.emit_out && idx == '0)) begin
      edge_total <= '0;
      drop_flag  <= 1'b0;
    end else if (edge_load) begin
      if (edge_ok) begin
        edge_total <= edge_total + EW'(1);
      end else begin
        drop_flag <= 1'b1;
      end
    end
  end

  // Walk registers: root, top of stack, cursor, depth, seen bits, order count and emit index.
  always_ff @(posedge clk) begin
    if (rst) begin
      check       <= 1'b0;
      i           <= '0;
      sp          <= '0;
      seen        <= '0;
      order_count <= '0;
      idx         <= '0;
    end else begin
      if (cmd.start_check || cmd.start_sort) begin
        check       <= cmd.start_check;
        i           <= NODE_W'(1);
        seen        <= '0;
        order_count <= '0;
      end
      if (cmd.root_next) begin
        i <= i + NODE_W'(1);
      end
      if (cmd.root_start) begin
        seen[i_m1[NODE_AW-1:0]] <= 1'b1;
        u  <= i;
        c  <= '0;
        sp <= NODE_W'(1);
      end
      if (cmd.retire) begin
        sp <= sp_m1;
      end
      if (order_we) begin
        order_count <= order_count + NODE_W'(1);
      end
      if (cmd.cursor_inc) begin
        c <= c + EW'(1);
      end
      if (cmd.match_take) begin
        v      <= e_tgt;
        seen_q <= seen[t_m1[NODE_AW-1:0]];
      end
      if (cmd.push) begin
        seen[v_m1[NODE_AW-1:0]] <= 1'b1;
        u  <= v;
        c  <= '0;
        sp <= sp + NODE_W'(1);
      end
      if (cmd.load_top) begin
        u <= stack_rdata[SW-1:EW];
        c <= stack_rdata[EW-1:0];
      end
      if (cmd.emit_start) begin
        idx <= sp_idx(order_count);
      end
      if (cmd.emit_out && idx != '0) begin
        idx <= idx - NODE_AW'(1);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.cyc_out || cmd.emit_out) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cyc_out) begin
      node_id       <= '0;
      cycle_found   <= 1'b1;
      edges_dropped <= drop_flag;
      last          <= 1'b1;
    end else if (cmd.emit_out) begin
      node_id       <= order_rdata;
      cycle_found   <= 1'b0;
      edges_dropped <= drop_flag;
      last          <= idx == '0;
    end
  end

endmodule

@@ src/dfs_topological_sort_unit.sv @@
// Channel  Direction  Handshake            Payload
// cfg      in         psel/penable/pwrite  paddr, pwdata (node_count)
// in       in         in_valid/in_stall    req_type, from_node, to_node
// out      out        out_valid/out_stall  node_id, cycle_found, edges_dropped, last
//
// Edge items are taken back to back while the unit is idle.
// A sort item holds in_stall high through the check walk and, when no cycle is
// found, the sort walk and the emission. Walk time is set by the single edge
// store read port: every visited node scans all stored edges, one read per edge.
// Emission reads each output item from the order store and then registers it.
// Synchronous reset clears control state; no clearing pass.
// A stalled output item holds the emit sequencer in place.
module dfs_topological_sort_unit #(
  parameter int MAX_EDGES = dts_pkg::MAX_EDGES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dts_pkg::ADDR_W-1:0]  paddr,
  input  logic [dts_pkg::DATA_W-1:0]  pwdata,
  output logic [dts_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        req_type,
  input  logic [dts_pkg::NODE_W-1:0]  from_node,
  input  logic [dts_pkg::NODE_W-1:0]  to_node,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [dts_pkg::NODE_W-1:0]  node_id,
  output logic                        cycle_found,
  output logic                        edges_dropped,
  output logic                        last
);
  import dts_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign pready   = 1'b1;
  assign in_stall = !cmd.idle;

  // Sequencer for the walks and the emit loop.
  dts_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  // Stores, walk registers and output register.
  dts_dp #(.MAX_EDGES(MAX_EDGES)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .in_valid      (in_valid),
    .req_type      (req_type),
    .from_node     (from_node),
    .to_node       (to_node),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .node_id       (node_id),
    .cycle_found   (cycle_found),
    .edges_dropped (edges_dropped),
    .last          (last)
  );

endmodule
